@@ src/bltd_pkg.sv @@
// Shared types, status codes and the inverse byte map of the byte-level token decoder.
`default_nettype none
package bltd_pkg;

  localparam int unsigned PointWidth = 21;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StBadLead   = 3'd1,
    StBadCont   = 3'd2,
    StTrunc     = 3'd3,
    StUnmapped  = 3'd4
  } status_e;

  typedef struct packed {
    status_e               status;
    logic [PointWidth-1:0] point;
    logic                  tok_end;
  } entry_t;

  // Returns the hit flag above the raw byte.
  function automatic logic [8:0] inv_map(input logic [PointWidth-1:0] cp);
    logic [7:0] lo;
    logic [8:0] res;
    lo  = cp[7:0];
    res = '0;
    if (cp[PointWidth-1:8] == '0) begin
      if ((lo >= 8'd33 && lo <= 8'd126) || (lo >= 8'd161 && lo <= 8'd172) ||
          (lo >= 8'd174)) begin
        res = {1'b1, lo};
      end
    end else if (cp[PointWidth-1:9] == '0 && cp[8] && lo <= 8'd67) begin
      if (lo <= 8'd32) begin
        res = {1'b1, lo};
      end else if (lo <= 8'd66) begin
        res = {1'b1, lo + 8'd94};
      end else begin
        res = {1'b1, 8'd173};
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ src/bltd_front.sv @@
// Front end: accepts UTF-8 bytes, assembles code points and classifies errors.
`default_nettype none
module bltd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            token_end_i,
  input  wire logic            q_ready_i,
  output logic                 q_push_o,
  output bltd_pkg::entry_t     q_entry_o
);

  logic [1:0]                          rem_q, rem_d, rem_n;
  logic [bltd_pkg::PointWidth-1:0]     point_q, point_d, point_n;
  logic                                accept;
  logic                                err;
  bltd_pkg::status_e                   err_status;
  logic                                result;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    rem_n      = rem_q;
    point_n    = point_q;
    err        = 1'b0;
    err_status = bltd_pkg::StOk;
    if (rem_q == 2'd0) begin
      if (!in_byte_i[7]) begin
        point_n = {13'd0, in_byte_i};
        rem_n   = 2'd0;
      end else if (in_byte_i[7:5] == 3'b110) begin
        point_n = {16'd0, in_byte_i[4:0]};
        rem_n   = 2'd1;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        point_n = {17'd0, in_byte_i[3:0]};
        rem_n   = 2'd2;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        point_n = {18'd0, in_byte_i[2:0]};
        rem_n   = 2'd3;
      end else begin
        err        = 1'b1;
        err_status = bltd_pkg::StBadLead;
      end
    end else begin
      if (in_byte_i[7:6] != 2'b10) begin
        err        = 1'b1;
        err_status = bltd_pkg::StBadCont;
      end else begin
        point_n = {point_q[bltd_pkg::PointWidth-7:0], in_byte_i[5:0]};
        rem_n   = rem_q - 2'd1;
      end
    end
    if (!err && rem_n != 2'd0 && token_end_i) begin
      err        = 1'b1;
      err_status = bltd_pkg::StTrunc;
    end
  end

  assign result = err || (rem_n == 2'd0);

  always_comb begin
    rem_d   = rem_q;
    point_d = point_q;
    if (accept) begin
      if (result) begin
        rem_d   = 2'd0;
        point_d = '0;
      end else begin
        rem_d   = rem_n;
        point_d = point_n;
      end
    end
  end

  assign q_push_o          = accept && result;
  assign q_entry_o.status  = err ? err_status : bltd_pkg::StOk;
  assign q_entry_o.point   = err ? '0 : point_n;
  assign q_entry_o.tok_end = token_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= 2'd0;
      point_q <= '0;
    end else begin
      rem_q   <= rem_d;
      point_q <= point_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && token_end_i |=> rem_q == 2'd0) else $error("sequence open after token end");
  a_end_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && token_end_i |-> q_push_o) else $error("token end gave no result");

endmodule
`default_nettype wire

@@ src/bltd_queue.sv @@
// Two-entry queue between the front end and the back end.
`default_nettype none
module bltd_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire bltd_pkg::entry_t push_entry_i,
  output logic                  ready_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output bltd_pkg::entry_t      pop_entry_o
);

  bltd_pkg::entry_t mem_q [bltd_pkg::QueueDepth];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o     = count_q != 2'(bltd_pkg::QueueDepth);
  assign valid_o     = count_q != 2'd0;
  assign pop_entry_o = mem_q[rd_ptr_q];
  assign do_push     = push_i && ready_o;
  assign do_pop      = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(bltd_pkg::QueueDepth)) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o) else $error("push into a full queue");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

@@ src/bltd_back.sv @@
// Back end: maps code points to raw bytes and holds the output register.
`default_nettype none
module bltd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire bltd_pkg::entry_t q_entry_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic [2:0]            status_o,
  output logic                  out_token_end_o
);

  logic              valid_q, valid_d;
  logic [7:0]        byte_q, byte_d;
  bltd_pkg::status_e status_q, status_d;
  logic              tok_end_q, tok_end_d;
  logic [8:0]        map_res;

  assign q_pop_o = q_valid_i && (!valid_q || out_ready_i);
  assign map_res = bltd_pkg::inv_map(q_entry_i.point);

  always_comb begin
    valid_d   = valid_q;
    byte_d    = byte_q;
    status_d  = status_q;
    tok_end_d = tok_end_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (q_pop_o) begin
      valid_d   = 1'b1;
      tok_end_d = q_entry_i.tok_end;
      if (q_entry_i.status != bltd_pkg::StOk) begin
        status_d = q_entry_i.status;
        byte_d   = 8'd0;
      end else if (map_res[8]) begin
        status_d = bltd_pkg::StOk;
        byte_d   = map_res[7:0];
      end else begin
        status_d = bltd_pkg::StUnmapped;
        byte_d   = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    status_q  <= status_d;
    tok_end_q <= tok_end_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign status_o        = status_q;
  assign out_token_end_o = tok_end_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_q != bltd_pkg::StOk |-> byte_q == 8'd0)
    else $error("error result carries a byte");

endmodule
`default_nettype wire

@@ src/byte_level_token_text_decode.sv @@
// Top level of the byte-level token text decoder.
// The result of a completing byte is registered in the queue, then in the output register.
// Throughput: one byte per cycle while the queue is not full; its ready drives in_ready_o.
// A two-entry queue and the output register let either side stall on its own.
// Reset clears the partial code point, the queue and the output valid flag.
`default_nettype none
module byte_level_token_text_decode (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       token_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      status_o,
  output logic            out_token_end_o
);

  logic             push, q_ready, q_valid, pop;
  bltd_pkg::entry_t push_entry, pop_entry;

  bltd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .token_end_i (token_end_i),
    .q_ready_i   (q_ready),
    .q_push_o    (push),
    .q_entry_o   (push_entry)
  );

  bltd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .ready_o      (q_ready),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .pop_entry_o  (pop_entry)
  );

  bltd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (pop_entry),
    .q_pop_o         (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .status_o        (status_o),
    .out_token_end_o (out_token_end_o)
  );

endmodule
`default_nettype wire
